// ===== rtl/triangle_quality_ratio_assert.svh =====
// Assertion macros for the triangle quality ratio block
`ifndef TRIANGLE_QUALITY_RATIO_ASSERT_SVH
`define TRIANGLE_QUALITY_RATIO_ASSERT_SVH
`ifndef NO_ASSERTIONS
// check a property outside reset
`define TQR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("triangle_quality_ratio: assertion failed");
// check a property on every edge, reset included
`define TQR_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("triangle_quality_ratio: assertion failed");
`else
`define TQR_ASSERT(lbl, prop)
`define TQR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/tqr_pkg.sv =====
// Types and constants shared by the triangle quality ratio block
`default_nettype none
package tqr_pkg;
	localparam int COORD_W = 16;
	localparam int IDX_W   = 11;
	localparam int DIFF_W  = 17;
	localparam int PROD_W  = 34;
	localparam int S_W     = 35;
	localparam int D_W     = 34;
	localparam int N_W     = 67;
	localparam int M_W     = 51;
	localparam int Q_W     = 32;
	localparam int R_W     = 35;

	// sqrt(3)/6 scaled by 2^32, rounded
	localparam logic [30:0] KQ32 = 31'd1239850262;

	localparam logic FUNC_POINT = 1'b0;
	localparam logic FUNC_TRI   = 1'b1;

	typedef struct packed {
		logic                      func;
		logic [IDX_W-1:0]          point_index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [IDX_W-1:0]          vertex_a;
		logic [IDX_W-1:0]          vertex_b;
		logic [IDX_W-1:0]          vertex_c;
		logic                      last_triangle;
	} item_t;

	typedef struct packed {
		logic [Q_W-1:0] quality;
		logic           degenerate;
		logic           last_result;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} vertex_t;

	// word carried through the divider stages
	typedef struct packed {
		logic [R_W-1:0] rem;
		logic [Q_W-1:0] low;
		logic [Q_W-1:0] quo;
		logic [D_W-1:0] d;
		logic           sat;
		logic           degen;
		logic           last;
	} div_t;
endpackage
`default_nettype wire

// ===== rtl/tqr_lane.sv =====
// One vertex lane: a copy of the point store with one registered read port
`default_nettype none
module tqr_lane
	import tqr_pkg::*;
#(
	parameter int MAX_POINTS = 1024
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire vertex_t          wr_data,
	input  wire logic [IDX_W-1:0] rd_idx,
	output vertex_t               vtx
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	vertex_t        mem [MAX_POINTS];
	vertex_t        rd_q;
	logic           bad_q;
	logic [16:0]    wr_m1;
	logic [16:0]    rd_m1;
	logic           wr_ok;
	logic           rd_ok;

	// map 1-based slots to addresses and check range
	always_comb begin
		wr_m1 = 17'(wr_idx) - 17'd1;
		rd_m1 = 17'(rd_idx) - 17'd1;
		wr_ok = (wr_idx != '0) && (17'(wr_idx) <= 17'(MAX_POINTS));
		rd_ok = (rd_idx != '0) && (17'(rd_idx) <= 17'(MAX_POINTS));
	end

	// write the point store
	always_ff @(posedge clk) begin
		if (wr_en && wr_ok) begin
			mem[wr_m1[AW-1:0]] <= wr_data;
		end
	end

	// read the point store, hold while the pipeline is frozen
	always_ff @(posedge clk) begin
		if (en) begin
			rd_q  <= mem[rd_m1[AW-1:0]];
			bad_q <= !rd_ok;
		end
	end

	// out-of-range slots read as the origin
	assign vtx = bad_q ? vertex_t'('0) : rd_q;
endmodule
`default_nettype wire

// ===== rtl/tqr_geom.sv =====
// Merge stage: edge vectors, squared lengths, cross product and scaled numerator
`default_nettype none
module tqr_geom
	import tqr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    valid_s1,
	input  wire logic    last_s1,
	input  wire vertex_t va,
	input  wire vertex_t vb,
	input  wire vertex_t vc,
	output logic         valid_s6,
	output div_t         word_s6
);
	logic signed [DIFF_W-1:0] e1x_s2, e1y_s2, e2x_s2, e2y_s2, e3x_s2, e3y_s2;
	logic signed [PROD_W-1:0] sq_s3 [6];
	logic signed [PROD_W-1:0] c1_s3, c2_s3;
	logic [S_W-1:0]           s_s4;
	logic [D_W-1:0]           d_s4, d_s5;
	logic [48:0]              pl_s5;
	logic [47:0]              ph_s5;
	logic [4:0]               v_q;
	logic [4:0]               last_q;
	logic signed [S_W-1:0]    cr;
	logic [D_W-1:0]           d_abs;
	logic [N_W-1:0]           num;
	logic [M_W-1:0]           m;

	// advance valid and last marks through the five stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], valid_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[3:0], last_s1};
		end
	end

	// edge vectors
	always_ff @(posedge clk) begin
		if (en) begin
			e1x_s2 <= DIFF_W'(vb.x) - DIFF_W'(va.x);
			e1y_s2 <= DIFF_W'(vb.y) - DIFF_W'(va.y);
			e2x_s2 <= DIFF_W'(vc.x) - DIFF_W'(vb.x);
			e2y_s2 <= DIFF_W'(vc.y) - DIFF_W'(vb.y);
			e3x_s2 <= DIFF_W'(va.x) - DIFF_W'(vc.x);
			e3y_s2 <= DIFF_W'(va.y) - DIFF_W'(vc.y);
		end
	end

	// squares and cross terms
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3[0] <= PROD_W'(e1x_s2) * PROD_W'(e1x_s2);
			sq_s3[1] <= PROD_W'(e1y_s2) * PROD_W'(e1y_s2);
			sq_s3[2] <= PROD_W'(e2x_s2) * PROD_W'(e2x_s2);
			sq_s3[3] <= PROD_W'(e2y_s2) * PROD_W'(e2y_s2);
			sq_s3[4] <= PROD_W'(e3x_s2) * PROD_W'(e3x_s2);
			sq_s3[5] <= PROD_W'(e3y_s2) * PROD_W'(e3y_s2);
			c1_s3    <= PROD_W'(e1y_s2) * PROD_W'(e3x_s2);
			c2_s3    <= PROD_W'(e1x_s2) * PROD_W'(e3y_s2);
		end
	end

	// twice the area as an absolute value
	always_comb begin
		cr    = S_W'(c1_s3) - S_W'(c2_s3);
		d_abs = cr[S_W-1] ? D_W'(-cr) : D_W'(cr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s4 <= S_W'(sq_s3[0][31:0]) + S_W'(sq_s3[1][31:0]) + S_W'(sq_s3[2][31:0])
			      + S_W'(sq_s3[3][31:0]) + S_W'(sq_s3[4][31:0]) + S_W'(sq_s3[5][31:0]);
			d_s4 <= d_abs;
		end
	end

	// scale S by the constant in two partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s5 <= 49'(KQ32) * 49'(s_s4[17:0]);
			ph_s5 <= 48'(KQ32) * 48'(s_s4[S_W-1:18]);
			d_s5  <= d_s4;
		end
	end

	// add the rounding half, drop 16 bits, test for saturation
	always_comb begin
		num = (N_W'(ph_s5) << 18) + N_W'(pl_s5) + (N_W'(d_s5) << 15);
		m   = num[N_W-1:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s6.rem   <= R_W'(m[M_W-1:Q_W]);
			word_s6.low   <= m[Q_W-1:0];
			word_s6.quo   <= '0;
			word_s6.d     <= d_s5;
			word_s6.sat   <= (D_W'(m[M_W-1:Q_W]) >= d_s5);
			word_s6.degen <= (d_s5 == '0);
			word_s6.last  <= last_q[3];
		end
	end

	assign valid_s6 = v_q[4];
endmodule
`default_nettype wire

// ===== rtl/tqr_div_stage.sv =====
// One restoring division step: one quotient bit per stage
`default_nettype none
module tqr_div_stage
	import tqr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire div_t word_in,
	output logic      valid_q,
	output div_t      word_q
);
	logic [R_W:0] trial;
	logic         ge;

	// shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {word_in.rem, word_in.low[Q_W-1]};
		ge    = trial >= (R_W+1)'(word_in.d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// a saturated word fills its quotient with ones
	always_ff @(posedge clk) begin
		if (en) begin
			word_q.rem   <= ge ? R_W'(trial - (R_W+1)'(word_in.d)) : trial[R_W-1:0];
			word_q.low   <= {word_in.low[Q_W-2:0], 1'b0};
			word_q.quo   <= {word_in.quo[Q_W-2:0], ge | word_in.sat};
			word_q.d     <= word_in.d;
			word_q.sat   <= word_in.sat;
			word_q.degen <= word_in.degen;
			word_q.last  <= word_in.last;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/triangle_quality_ratio.sv =====
// Top level of the triangle quality ratio block
// Usage:
//   The item channel (item, item_valid, item_stall) takes point writes and
//   triangles. A point write (func 0) stores (x, y) at a 1-based slot and gives
//   no result. A triangle (func 1) names three slots and gives one result word
//   on the result channel (result, result_valid, result_stall): quality in
//   unsigned Q16.16, 1.0 for an equilateral triangle, all ones when saturated
//   or when the area is zero (then degenerate is set), and last_result.
//   Three lanes each hold a copy of the point store and fetch one vertex; a
//   merge stage forms the edge sums and twice the area, and a 32-stage
//   divider pipeline gives one quotient bit per stage.
//   Throughput: one word per cycle while no result is stalled; a point write
//   may feed a triangle in the very next cycle.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   item_stall rises until the result is taken.
//   Reset clears all valid marks; the point store is not cleared, so a slot
//   must be written before a triangle uses it.
`default_nettype none
`include "triangle_quality_ratio_assert.svh"
module triangle_quality_ratio
	import tqr_pkg::*;
#(
	parameter int MAX_POINTS = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t item,
	input  wire logic  item_valid,
	output logic       item_stall,
	output result_t    result,
	output logic       result_valid,
	input  wire logic  result_stall
);
	localparam int DIV_STAGES = Q_W;

	logic    adv;
	logic    accept;
	logic    wr_en;
	logic    v_s1;
	logic    last_s1;
	vertex_t wr_data;
	vertex_t va, vb, vc;
	logic    valid_s6;
	div_t    word_s6;
	logic    dv   [DIV_STAGES+1];
	div_t    dword [DIV_STAGES+1];

	// freeze the pipeline while a result word is stalled
	assign adv        = !(result_valid && result_stall);
	assign item_stall = !adv;
	assign accept     = item_valid && adv;
	assign wr_en      = accept && (item.func == FUNC_POINT);
	assign wr_data    = '{x: item.point_x, y: item.point_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept && (item.func == FUNC_TRI);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= item.last_triangle;
		end
	end

	// vertex fetch lanes
	tqr_lane #(.MAX_POINTS(MAX_POINTS)) u_lane_a (
		.clk(clk), .en(adv), .wr_en(wr_en), .wr_idx(item.point_index),
		.wr_data(wr_data), .rd_idx(item.vertex_a), .vtx(va)
	);
	tqr_lane #(.MAX_POINTS(MAX_POINTS)) u_lane_b (
		.clk(clk), .en(adv), .wr_en(wr_en), .wr_idx(item.point_index),
		.wr_data(wr_data), .rd_idx(item.vertex_b), .vtx(vb)
	);
	tqr_lane #(.MAX_POINTS(MAX_POINTS)) u_lane_c (
		.clk(clk), .en(adv), .wr_en(wr_en), .wr_idx(item.point_index),
		.wr_data(wr_data), .rd_idx(item.vertex_c), .vtx(vc)
	);

	// merge the lanes into S and D
	tqr_geom u_geom (
		.clk(clk), .arst_n(arst_n), .en(adv), .valid_s1(v_s1), .last_s1(last_s1),
		.va(va), .vb(vb), .vc(vc), .valid_s6(valid_s6), .word_s6(word_s6)
	);

	// divider pipeline
	assign dv[0]    = valid_s6;
	assign dword[0] = word_s6;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		tqr_div_stage u_stage (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_in(dv[i]), .word_in(dword[i]),
			.valid_q(dv[i+1]), .word_q(dword[i+1])
		);
	end

	assign result_valid       = dv[DIV_STAGES];
	assign result.quality     = dword[DIV_STAGES].quo;
	assign result.degenerate  = dword[DIV_STAGES].degen;
	assign result.last_result = dword[DIV_STAGES].last;

	`TQR_ASSERT(a_degen_sat, result_valid && result.degenerate |-> result.quality == '1)
	`TQR_ASSERT(a_point_no_result, accept && (item.func == FUNC_POINT) |=> !v_s1)
	`TQR_ASSERT(a_freeze_holds, result_valid && result_stall |=> $stable(v_s1) && $stable(valid_s6))
	`TQR_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !result_valid)
endmodule
`default_nettype wire
